[rtl/byte_argsort_descending_core_assert.svh]
// Assertion macros shared by the argsort RTL
`ifndef BYTE_ARGSORT_DESCENDING_CORE_ASSERT_SVH
`define BYTE_ARGSORT_DESCENDING_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BAD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define BAD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/bad_pkg.sv]
// Shared constants and types for the byte argsort block
`default_nettype none
package bad_pkg;
  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);

  // item passed from loader to sorter: a finished list
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            ovf;
  } list_cmd_t;
endpackage
`default_nettype wire

[rtl/byte_argsort_descending_core.sv]
// Top level of the byte argsort block
// Loading: one item per cycle; after a last item the input is held off until the
// final result of the run is registered and the idle back end releases the loader.
// Sorting: each result is one pass of pipelined reads of the value memory, each read
// compared against the best so far, then an emit that waits on the output handshake.
// Reset (rst, synchronous): empty list.
`default_nettype none
module byte_argsort_descending_core import bad_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // item_value
  input  wire logic        s_tlast,   // last_item
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // position[5:0], ranked_value[13:6], 0
  output logic             m_tuser,   // overflowed
  output logic             m_tlast    // end_of_run
);
  logic            wr_en, cmd_valid, cmd_ready;
  logic [IdxW-1:0] wr_addr, pos;
  logic [7:0]      wr_data, val;
  list_cmd_t       cmd;

  bad_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_value(s_tdata),
    .in_last(s_tlast), .wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd_ready, .cmd
  );

  bad_back u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_pos(pos), .out_value(val),
    .out_ovf(m_tuser), .out_last(m_tlast)
  );

  assign m_tdata = {2'b00, val, pos};
endmodule
`default_nettype wire

[rtl/bad_front.sv]
// Front end: stores incoming bytes, closes a list on the last item
`default_nettype none
module bad_front import bad_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_value,
  input  wire logic             in_last,
  output logic                  wr_en,
  output logic [IdxW-1:0]       wr_addr,
  output logic [7:0]            wr_data,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output list_cmd_t             cmd
);
  logic [CntW-1:0] loaded_count;
  logic            overflow_flag;
  logic            busy;   // a closed list is owned by the back end
  logic            acc;
  logic            room;

  assign room     = loaded_count < CntW'(MaxItems);
  assign in_ready = !busy && !cmd_valid;
  assign acc      = in_valid && in_ready;
  assign wr_en    = acc && room;
  assign wr_addr  = loaded_count[IdxW-1:0];
  assign wr_data  = in_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      overflow_flag <= 1'b0;
      cmd_valid     <= 1'b0;
      busy          <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
      if (acc) begin
        if (in_last) begin
          cmd_valid     <= 1'b1;
          busy          <= 1'b1;
          cmd.count     <= room ? loaded_count + 1'b1 : loaded_count;
          cmd.ovf       <= overflow_flag || !room;
          loaded_count  <= '0;
          overflow_flag <= 1'b0;
        end else if (room) begin
          loaded_count <= loaded_count + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end else if (busy && !cmd_valid && cmd_ready) begin
        // back end idle again: the list has been read out
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/bad_back.sv]
// Back end: selection sort over the value memory, one result per pass
`default_nettype none
module bad_back import bad_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [IdxW-1:0] wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire list_cmd_t   cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [IdxW-1:0]  out_pos,
  output logic [7:0]       out_value,
  output logic             out_ovf,
  output logic             out_last
);
  `include "byte_argsort_descending_core_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;
  state_t state;

  logic [7:0]          mem [MaxItems];
  logic [MaxItems-1:0] used;
  logic [CntW-1:0]     count, emitted;
  logic                ovf;
  logic [IdxW-1:0]     scan, best_idx, rd_idx;
  logic [7:0]          best_val, rd_val;
  logic                have_best, issuing, rd_vld;
  logic                take, scan_end, emit_go;

  // registered read port; the data for a scan address arrives in the cycle after it
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_val <= mem[scan];
  end

  assign cmd_ready = (state == S_IDLE);

  // strict greater keeps the lower position on ties
  assign take     = rd_vld && !used[rd_idx] && (!have_best || rd_val > best_val);
  assign scan_end = CntW'(scan) + 1'b1 >= count;
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (cmd_valid) begin
            count     <= cmd.count;
            ovf       <= cmd.ovf;
            emitted   <= '0;
            used      <= '0;
            scan      <= '0;
            issuing   <= 1'b1;
            have_best <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= issuing;
          rd_idx <= scan;
          if (issuing) begin
            if (scan_end) issuing <= 1'b0;
            else scan <= scan + 1'b1;
          end
          if (take) begin
            best_idx  <= rd_idx;
            best_val  <= rd_val;
            have_best <= 1'b1;
          end
          // final entry compared this cycle
          if (rd_vld && !issuing) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_pos        <= best_idx;
            out_value      <= best_val;
            out_ovf        <= ovf;
            out_last       <= (emitted + 1'b1 == count);
            used[best_idx] <= 1'b1;
            emitted        <= emitted + 1'b1;
            scan           <= '0;
            issuing        <= 1'b1;
            have_best      <= 1'b0;
            state          <= (emitted + 1'b1 == count) ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BAD_ASSERT_IMP(a_cnt_ok, state == S_SCAN, count != '0 && count <= CntW'(MaxItems))
  `BAD_ASSERT_IMP(a_emit_best, state == S_EMIT, have_best)
  `BAD_ASSERT_NXT(a_last_idle, out_valid && out_ready && out_last && state == S_IDLE, !out_valid || !out_last || state != S_IDLE)
endmodule
`default_nettype wire

[verif/byte_argsort_descending_core_test.sv]
// Testbench for the byte argsort block: streams lists in, checks ranked results
`default_nettype none
module byte_argsort_descending_core_test;
  import bad_pkg::*;

  localparam int WatchLimit = 200000;
  localparam int HoldLen = 600;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [5:0] position;
    logic [7:0] value;
    logic       ovf;
    logic       eor;
  } rank_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  byte_item_t pending_items[$];
  rank_t      ranks_due[$];

  // predictor copy of the block state
  logic [7:0] list_vals[MaxItems];
  int         list_len = 0;
  logic       list_ovf = 1'b0;

  int  fails = 0;
  int  watch = 0;
  int  sent = 0;
  bit  idle_free = 1'b0;     // no random idling while set
  bit  hold_req = 1'b0;      // sequence asks for one long receiver hold-off
  bit  hold_done = 1'b0;
  int  hold_cycles = 0;      // long receiver hold-off still to run
  bit  src_pause = 1'b0;

  always #10 clk = ~clk;

  byte_argsort_descending_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // Model one accepted item: store or drop, and on last rank the list.
  task automatic rank_list(input byte_item_t it);
    int  order[MaxItems];
    int  j;
    int  cur;
    rank_t r;
    if (list_len < MaxItems) begin
      list_vals[list_len] = it.value;
      list_len++;
    end else begin
      list_ovf = 1'b1;
    end
    if (!it.last) return;
    // stable insertion sort: larger first, ties by lower position
    for (int i = 0; i < list_len; i++) begin
      cur = i;
      j = i;
      while (j > 0 && list_vals[cur] > list_vals[order[j-1]]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int k = 0; k < list_len; k++) begin
      r.position = order[k][5:0];
      r.value    = list_vals[order[k]];
      r.ovf      = list_ovf;
      r.eor      = (k == list_len - 1);
      ranks_due.push_back(r);
    end
    list_len = 0;
    list_ovf = 1'b0;
  endtask

  task automatic queue_list(input int len, input int mode);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: it.value = 8'($urandom_range(0, 255));
        1: it.value = 8'($urandom_range(0, 3));   // heavy ties
        2: it.value = 8'(i);
        default: it.value = 8'(255 - i);
      endcase
      it.last = (i == len - 1);
      pending_items.push_back(it);
    end
  endtask

  // Sender: offers items from the pending queue.
  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.value = s_tdata;
        it.last  = s_tlast;
        rank_list(it);
        sent++;
      end
      if ((!s_tvalid || s_tready) ) begin
        if (pending_items.size() > 0 && !src_pause &&
            (idle_free || $urandom_range(0, 99) >= 14)) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.value;
          s_tlast  <= it.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    rank_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (ranks_due.size() == 0) begin
          $display("%0t: unexpected result, actual %h last %b", $realtime, m_tdata, m_tlast);
          fails++;
        end else begin
          e = ranks_due.pop_front();
          if (m_tdata[5:0] !== e.position || m_tdata[13:6] !== e.value ||
              m_tuser !== e.ovf || m_tlast !== e.eor) begin
            $display("%0t: expected %0d/%0d/%b/%b, actual %0d/%0d/%b/%b",
                     $realtime, e.position, e.value, e.ovf, e.eor,
                     m_tdata[5:0], m_tdata[13:6], m_tuser, m_tlast);
            fails++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done   <= 1'b1;
        hold_cycles <= HoldLen;
        m_tready    <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= idle_free || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      watch <= 0;
    end else begin
      watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("byte_argsort_descending_core test failed");
        $finish;
      end
    end
  end

  task automatic drain;
    while (pending_items.size() > 0 || s_tvalid || ranks_due.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: single items at the extremes, ties, ordered lists
    queue_list(1, 0);
    pending_items[0].value = 8'hff;
    pending_items.push_back('{8'h00, 1'b1});
    pending_items.push_back('{8'h80, 1'b0});
    pending_items.push_back('{8'h80, 1'b0});
    pending_items.push_back('{8'h7f, 1'b0});
    pending_items.push_back('{8'hff, 1'b0});
    pending_items.push_back('{8'h80, 1'b1});
    queue_list(6, 2);
    queue_list(6, 3);
    queue_list(4, 1);
    drain();

    // receiver holds off while the sender keeps offering: block fills and stalls
    hold_req = 1'b1;
    queue_list(8, 0);
    queue_list(5, 0);
    queue_list(7, 1);
    drain();

    // sender pause until all results in, then a full list and an overflowing one
    src_pause = 1'b1;
    drain();
    repeat (5) @(posedge clk);
    src_pause = 1'b0;
    queue_list(64, 0);
    queue_list(70, 1);        // last item dropped, run still comes out
    drain();

    // random lists, mostly short, idling switched off for a stretch
    while (sent < 370) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 68) : $urandom_range(1, 8);
      queue_list(len, $urandom_range(0, 3) == 0 ? 1 : 0);
      if (sent > 250 && sent < 300) idle_free = 1'b1;
      else idle_free = 1'b0;
      drain();
    end
    drain();
    repeat (100) @(posedge clk);
    if (fails == 0 && ranks_due.size() == 0) begin
      $display("byte_argsort_descending_core test passed");
    end else begin
      $display("byte_argsort_descending_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
